// File: rtl/pru_pkg.sv
// Shared types, constants and helpers for the print raster unpacker.
package pru_pkg;

  localparam int LINE_PIXELS_DEF = 384;
  localparam int OFFSET_BITS_DEF = 20;

  localparam int ADDR_W  = 20;
  localparam int CNT_W   = 4;
  localparam int LINES_W = 12;
  localparam int THR_W   = 20;
  localparam int PKT_W   = 20;
  localparam int OUT_W   = 48;
  localparam int PADDR_W = 3;
  localparam int APB_W   = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(300000);

  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_RUN     = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } pru_op_t;

  // register word index, taken from paddr[2]
  typedef enum logic {
    REG_DOT_MODE = 1'b0,
    REG_STOP_THR = 1'b1
  } pru_reg_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic finish;
    logic emit;
  } pru_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_beat;
    logic div_done;
  } pru_sts_t;

  // low n bits set, n saturating at 8
  function automatic logic [7:0] ones(input logic [CNT_W-1:0] n);
    logic [7:0] m;
    m = 8'hFF;
    if (n < CNT_W'(8)) begin
      m = ~(8'hFF << n[2:0]);
    end
    return m;
  endfunction

endpackage

// File: rtl/pru_div.sv
// Line count from the packet tally: divide by line width through a reciprocal multiply.
module pru_div import pru_pkg::*; #(
  parameter int LINE_PIXELS = LINE_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PKT_W-1:0]   dividend,
  output logic [LINES_W-1:0] quotient,
  output logic               done
);

  // floor(x / d) = (x * ceil(2^SH / d)) >> SH for every x below 2^PKT_W
  localparam int SH = PKT_W + $clog2(LINE_PIXELS);
  localparam int MW = PKT_W + 1;
  localparam int PW = PKT_W + MW + LINES_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SH) + 64'(LINE_PIXELS) - 64'd1) / 64'(LINE_PIXELS);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  logic [PW-1:0] prod;

  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // only the low quotient bits matter: the line count wraps
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= prod[SH +: LINES_W];
    end
  end

endmodule

// File: rtl/pru_dp.sv
// Datapath: pixel offset, line count, packet tally, burst generation and output register.
module pru_dp import pru_pkg::*; #(
  parameter int LINE_PIXELS = LINE_PIXELS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  pru_cmd_t         cmd,
  output pru_sts_t         sts,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_data,
  input  logic             dot_mode,
  input  logic [THR_W-1:0] stop_thr,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  localparam int CW = (OFFSET_BITS > ADDR_W) ? OFFSET_BITS : ADDR_W;
  localparam int OUT_PAD = OUT_W - (ADDR_W + CNT_W + 8 + LINES_W + 1);
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  pru_op_t op_in;
  pru_op_t op_r;

  logic [OFFSET_BITS-1:0] offset;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS-1:0] room;
  logic [LINES_W-1:0]     lines;
  logic [LINES_W-1:0]     line_add;
  logic [LINES_W-1:0]     quot;
  logic                   stop_sent;
  logic                   stop_hit;
  logic                   stop_r;
  logic [PKT_W-1:0]       pkt;
  logic [PKT_W:0]         pkt_sum;
  logic [PKT_W-1:0]       pkt_sat;
  logic [7:0]             data_r;
  logic [6:0]             req;
  logic [6:0]             n;
  logic [6:0]             left;
  logic [CNT_W-1:0]       beat_cnt;
  logic [7:0]             beat_bits;
  logic [CW-1:0]          start_ext;

  logic [ADDR_W-1:0]      o_addr;
  logic [CNT_W-1:0]       o_cnt;
  logic [7:0]             o_bits;
  logic [LINES_W-1:0]     o_lines;
  logic                   o_stop;
  logic                   div_done;

  assign op_in = pru_op_t'(in_op);

  // pixels the incoming byte may write before the offset saturates
  assign room    = OFFSET_MAX - offset;
  assign req     = (op_in == OP_RAW) ? 7'd8 : in_data[6:0];
  assign n       = (room < OFFSET_BITS'(req)) ? room[6:0] : req;
  assign pkt_sum = {1'b0, pkt} + (PKT_W+1)'(req);
  assign pkt_sat = pkt_sum[PKT_W] ? {PKT_W{1'b1}} : pkt_sum[PKT_W-1:0];

  assign line_add = (op_r == OP_RAW) ? LINES_W'(1) : quot;
  assign stop_hit = dot_mode && !stop_sent && (CW'(offset) > CW'(stop_thr));

  assign beat_cnt  = (left > 7'd8) ? CNT_W'(8) : left[CNT_W-1:0];
  assign beat_bits = ((op_r == OP_RAW) ? data_r : {8{data_r[7]}}) & ones(beat_cnt);
  assign start_ext = CW'(start);

  pru_div #(.LINE_PIXELS(LINE_PIXELS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (pkt),
    .quotient (quot),
    .done     (div_done)
  );

  assign sts.out_free  = !m_tvalid || m_tready;
  assign sts.last_beat = (left <= 7'd8);
  assign sts.div_done  = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      lines     <= '0;
      stop_sent <= 1'b0;
      pkt       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        unique case (op_in)
          OP_RESTART: begin
            offset    <= '0;
            lines     <= '0;
            stop_sent <= 1'b0;
            pkt       <= '0;
          end
          OP_RAW: offset <= offset + OFFSET_BITS'(n);
          OP_RUN: begin
            offset <= offset + OFFSET_BITS'(n);
            pkt    <= pkt_sat;
          end
          OP_NONE: ;
        endcase
      end
      if (cmd.finish) begin
        lines <= lines + line_add;
        pkt   <= '0;
        if (stop_hit) begin
          stop_sent <= 1'b1;
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // per-item working registers and the output beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_in;
      data_r <= in_data;
      stop_r <= 1'b0;
      if (op_in == OP_RESTART) begin
        start <= '0;
        left  <= '0;
      end else begin
        start <= offset;
        left  <= n;
      end
    end
    if (cmd.finish) begin
      stop_r <= stop_hit;
    end
    if (cmd.emit) begin
      o_addr  <= start_ext[ADDR_W-1:0];
      o_cnt   <= beat_cnt;
      o_bits  <= beat_bits;
      o_lines <= lines;
      o_stop  <= stop_r && sts.last_beat;
      m_tlast <= sts.last_beat;
      start   <= start + OFFSET_BITS'(8);
      left    <= left - 7'd8;
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, o_stop, o_lines, o_bits, o_cnt, o_addr};

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("beat loaded over a pending result");

  a_stop_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_stop) |-> m_tlast)
    else $error("flow stop on a beat that is not last");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (stop_sent && !(cmd.load && op_in == OP_RESTART)) |=> stop_sent)
    else $error("stop flag dropped without restart");

endmodule

// File: rtl/pru_ctrl.sv
// Controller: sequences load, packet-end divide, line update and burst beats.
module pru_ctrl import pru_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [1:0] in_op,
  input  logic     in_eop,
  output logic     in_ready,
  output pru_cmd_t cmd,
  input  pru_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH,
    ST_EMIT
  } state_t;

  state_t  state;
  state_t  state_next;
  pru_op_t op;

  assign op       = pru_op_t'(in_op);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.div_start = (state == ST_DIV_GO);
    cmd.finish    = (state == ST_FINISH);
    cmd.emit      = (state == ST_EMIT) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op)
            OP_NONE:    state_next = ST_IDLE;
            OP_RESTART: state_next = ST_EMIT;
            OP_RAW:     state_next = in_eop ? ST_FINISH : ST_EMIT;
            OP_RUN:     state_next = in_eop ? ST_DIV_GO : ST_EMIT;
          endcase
        end
      end
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (sts.div_done) state_next = ST_FINISH;
      ST_FINISH:   state_next = ST_EMIT;
      ST_EMIT:     if (cmd.emit && sts.last_beat) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/print_raster_unpacker.sv
// Sequence: an accepted byte goes to its burst beats; at a packet end a raw byte first takes the
// line update (FINISH), a run byte the divide (DIV_GO, DIV_WAIT: multiply by the reciprocal of the
// line width) and then the update. Flow: a new item is taken only once every beat of the last one
// is loaded; a held-back beat stalls the burst; the next item is taken while the last beat waits.
// Reset: synchronous, active high; clears offset, line count, packet tally and stop flag,
// and returns dot_matrix_mode to 0 and stop_threshold to 300000.
module print_raster_unpacker import pru_pkg::*; #(
  parameter int LINE_PIXELS = LINE_PIXELS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic [1:0]         s_tuser,   // [1:0] operation
  input  logic               s_tlast,   // end_of_packet
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // [19:0] write_address, [23:20] pixel_count,
                                        // [31:24] pixel_bits, [43:32] line_count,
                                        // [44] flow_stop, [47:45] zero
  output logic               m_tlast,   // last
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  logic             dot_mode;
  logic [THR_W-1:0] stop_thr;
  logic             cfg_wr;
  pru_reg_t         reg_sel;
  pru_cmd_t         cmd;
  pru_sts_t         sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = pru_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_mode <= 1'b0;
      stop_thr <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DOT_MODE: dot_mode <= pwdata[0];
        REG_STOP_THR: stop_thr <= pwdata[THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DOT_MODE: prdata = APB_W'(dot_mode);
      REG_STOP_THR: prdata = APB_W'(stop_thr);
    endcase
  end

  pru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_eop   (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pru_dp #(
    .LINE_PIXELS (LINE_PIXELS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (s_tuser),
    .in_data  (s_tdata),
    .dot_mode (dot_mode),
    .stop_thr (stop_thr),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for print_raster_unpacker: stream stimulus, APB setup, burst scoreboard.
module testbench;
  import pru_pkg::*;

  localparam int LINE_PX = LINE_PIXELS_DEF;
  localparam logic [ADDR_W-1:0] OFFSET_MAX = ADDR_W'((1 << OFFSET_BITS_DEF) - 1);
  localparam int PKT_MAX = (1 << PKT_W) - 1;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   cnt;
    logic [7:0]         bits;
    logic [LINES_W-1:0] lines;
    logic               stop;
    logic               last;
  } burst_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic [1:0]         s_tuser;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tlast;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  // shadow of the block's registers and state
  logic               cfg_dot_mode;
  logic [THR_W-1:0]   cfg_threshold;
  logic [ADDR_W-1:0]  pix_offset;
  logic [LINES_W-1:0] lines_rx;
  logic               stop_sent;
  logic [PKT_W-1:0]   pkt_pixels;

  burst_t pending_bursts[$];
  int     errors;
  int     cycles;
  bit     no_stall;

  print_raster_unpacker i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 30) $display("ERROR t=%0t: %s", $time, msg);
  endtask

  // expand one accepted byte into the bursts it must produce
  task automatic unpack_byte(input pru_op_t op, input logic [7:0] data, input logic eop);
    logic [ADDR_W-1:0] start, room, n, req;
    logic [CNT_W-1:0]  cnt;
    logic [7:0]        mask;
    logic              value, stop;
    int                total, bursts, left;
    if (op == OP_NONE) return;
    if (op == OP_RESTART) begin
      pix_offset = '0;
      lines_rx = '0;
      stop_sent = 1'b0;
      pkt_pixels = '0;
      pending_bursts.push_back('{addr: '0, cnt: '0, bits: '0, lines: '0, stop: 1'b0,
                                 last: 1'b1});
      return;
    end
    start = pix_offset;
    room = OFFSET_MAX - pix_offset;
    value = 1'b0;
    stop = 1'b0;
    if (op == OP_RAW) begin
      n = (room < 8) ? room : ADDR_W'(8);
    end else begin
      req = ADDR_W'(data[6:0]);
      value = data[7];
      n = (room < req) ? room : req;
      total = int'(pkt_pixels) + int'(req);
      pkt_pixels = (total > PKT_MAX) ? PKT_W'(PKT_MAX) : PKT_W'(total);
    end
    pix_offset = pix_offset + n;
    if (eop) begin
      if (op == OP_RAW) lines_rx = lines_rx + LINES_W'(1);
      else lines_rx = lines_rx + LINES_W'(int'(pkt_pixels) / LINE_PX);
      pkt_pixels = '0;
      if (cfg_dot_mode && pix_offset > cfg_threshold && !stop_sent) begin
        stop_sent = 1'b1;
        stop = 1'b1;
      end
    end
    bursts = (int'(n) + 7) / 8;
    if (bursts == 0) begin
      pending_bursts.push_back('{addr: start, cnt: '0, bits: '0, lines: lines_rx, stop: stop,
                                 last: 1'b1});
      return;
    end
    for (int k = 0; k < bursts; k++) begin
      left = int'(n) - 8 * k;
      cnt = (left < 8) ? CNT_W'(left) : CNT_W'(8);
      mask = (cnt >= 8) ? 8'hFF : 8'((9'd1 << cnt) - 1);
      pending_bursts.push_back('{
        addr: start + ADDR_W'(8 * k), cnt: cnt,
        bits: (op == OP_RAW) ? (data & mask) : (value ? mask : 8'h00),
        lines: lines_rx, stop: (k == bursts - 1) ? stop : 1'b0,
        last: (k == bursts - 1)});
    end
  endtask

  // input side predicts, output side compares against the oldest expectation
  always @(posedge clk) begin : scoreboard
    burst_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) unpack_byte(pru_op_t'(s_tuser), s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (pending_bursts.size() == 0) begin
          report_mismatch($sformatf("unexpected beat tdata=%h", m_tdata));
        end else begin
          want = pending_bursts.pop_front();
          if (m_tdata[19:0] !== want.addr)
            report_mismatch($sformatf("write_address %h, want %h", m_tdata[19:0], want.addr));
          if (m_tdata[23:20] !== want.cnt)
            report_mismatch($sformatf("pixel_count %0d, want %0d", m_tdata[23:20], want.cnt));
          if (m_tdata[31:24] !== want.bits)
            report_mismatch($sformatf("pixel_bits %h, want %h", m_tdata[31:24], want.bits));
          if (m_tdata[43:32] !== want.lines)
            report_mismatch($sformatf("line_count %0d, want %0d", m_tdata[43:32], want.lines));
          if (m_tdata[44] !== want.stop)
            report_mismatch($sformatf("flow_stop %b, want %b", m_tdata[44], want.stop));
          if (m_tdata[47:45] !== 3'b000)
            report_mismatch($sformatf("pad bits %b", m_tdata[47:45]));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready = no_stall ? 1'b1 : ($urandom_range(0, 99) >= 28);
  end

  task automatic send_byte(input pru_op_t op, input logic [7:0] data, input logic eop);
    @(negedge clk);
    while (!no_stall && $urandom_range(0, 99) < 28) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = data;
    s_tlast = eop;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending, wait for every expected beat, then let the block settle
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_bursts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_register(input pru_reg_t r);
    logic [APB_W-1:0] want, got;
    want = (r == REG_DOT_MODE) ? APB_W'(cfg_dot_mode) : APB_W'(cfg_threshold);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {r, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (got !== want) report_mismatch($sformatf("reg %s reads %h, want %h", r.name(), got, want));
  endtask

  // junk above the field checks that only the field is kept
  task automatic set_register(input pru_reg_t r, input logic [THR_W-1:0] value);
    logic [APB_W-1:0] word;
    word = $urandom;
    if (r == REG_DOT_MODE) word[0] = value[0];
    else word[THR_W-1:0] = value;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {r, 2'b00};
    pwdata = word;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (r == REG_DOT_MODE) cfg_dot_mode = word[0];
    else cfg_threshold = word[THR_W-1:0];
    check_register(r);
  endtask

  task automatic test_reset_registers();
    check_register(REG_DOT_MODE);
    check_register(REG_STOP_THR);
  endtask

  task automatic test_raw_bytes();
    send_byte(OP_RESTART, 8'h00, 1'b0);
    send_byte(OP_RAW, 8'h00, 1'b0);
    send_byte(OP_RAW, 8'hFF, 1'b0);
    send_byte(OP_RAW, 8'hA5, 1'b1);
    send_byte(OP_NONE, 8'hFF, 1'b1);
    send_byte(OP_RAW, 8'h5A, 1'b1);
  endtask

  task automatic test_run_bytes();
    send_byte(OP_RUN, 8'h00, 1'b0);   // zero count: status only
    send_byte(OP_RUN, 8'h80, 1'b0);
    send_byte(OP_RUN, 8'h7F, 1'b0);
    send_byte(OP_RUN, 8'hFF, 1'b0);
    send_byte(OP_RUN, 8'h81, 1'b0);
    send_byte(OP_RUN, 8'h09, 1'b0);
    send_byte(OP_RUN, 8'hFF, 1'b1);   // 391 pixels in the packet: one line
    // run pixels ahead of a raw packet end are dropped from the tally
    for (int i = 0; i < 4; i++) send_byte(OP_RUN, 8'hFF, 1'b0);
    send_byte(OP_RAW, 8'h3C, 1'b1);
    send_byte(OP_RESTART, 8'hC3, 1'b1);
  endtask

  task automatic test_flow_stop();
    drain();
    set_register(REG_DOT_MODE, THR_W'(1));
    set_register(REG_STOP_THR, THR_W'(0));
    send_byte(OP_RAW, 8'h11, 1'b1);
    send_byte(OP_RAW, 8'h22, 1'b1);   // already sent, must stay low
    send_byte(OP_RESTART, 8'h00, 1'b0);
    drain();
    set_register(REG_STOP_THR, THR_W'(20));
    for (int i = 0; i < 3; i++) send_byte(OP_RAW, 8'h81, 1'b0);
    send_byte(OP_RUN, 8'h84, 1'b1);
  endtask

  task automatic send_random_packet(ref int sent);
    int pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_byte(OP_RESTART, 8'($urandom), 1'($urandom));
      sent++;
    end else if (pick < 14) begin
      send_byte(OP_NONE, 8'($urandom), 1'($urandom));
    end else begin
      // broken packets stop early with no packet end
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_byte($urandom_range(0, 1) ? OP_RUN : OP_RAW, 8'($urandom),
                  (pick >= 20) && (i == len - 1));
        sent++;
      end
    end
  endtask

  task automatic random_phase(input int items, input bit pause_midway);
    int sent;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < items) begin
      send_random_packet(sent);
      if (pause_midway && !paused && sent >= items / 2) begin
        drain();
        paused = 1;
      end
    end
  endtask

  task automatic test_random_traffic();
    drain();
    set_register(REG_DOT_MODE, THR_W'(1));
    set_register(REG_STOP_THR, THR_W'($urandom_range(0, 600)));
    random_phase(25, 1'b0);
    drain();
    set_register(REG_DOT_MODE, THR_W'(0));
    set_register(REG_STOP_THR, THR_W'($urandom_range(0, 3000)));
    random_phase(25, 1'b1);
    drain();
    set_register(REG_DOT_MODE, THR_W'(1));
    set_register(REG_STOP_THR, THR_W'($urandom_range(0, 3000)));
    random_phase(25, 1'b0);
  endtask

  // back-to-back traffic with both sides always ready
  task automatic test_no_idle_stretch();
    drain();
    no_stall = 1;
    set_register(REG_STOP_THR, THR_W'(600));
    set_register(REG_DOT_MODE, THR_W'(1));
    send_byte(OP_RESTART, 8'h00, 1'b0);
    for (int i = 0; i < 8; i++) send_byte(OP_RUN, 8'($urandom) | 8'h40, 1'b0);
    send_byte(OP_RUN, 8'hFF, 1'b1);
    send_byte(OP_RAW, 8'hFF, 1'b0);
    drain();
    no_stall = 0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_RAW;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    no_stall = 0;
    cfg_dot_mode = 1'b0;
    cfg_threshold = THR_RESET;
    pix_offset = '0;
    lines_rx = '0;
    stop_sent = 1'b0;
    pkt_pixels = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_reset_registers();
    test_raw_bytes();
    test_run_bytes();
    test_flow_stop();
    test_random_traffic();
    test_no_idle_stretch();
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pru_pkg.sv
rtl/pru_div.sv
rtl/pru_dp.sv
rtl/pru_ctrl.sv
rtl/print_raster_unpacker.sv
tb/testbench.sv
